FILE: sv/bscp_pkg.sv
// Shared types, constants and helpers for the bit string concat packer.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package bscp_pkg;

    localparam logic [7:0] BYTE_MASK = 8'hFF;
    localparam logic [3:0] BYTE_BITS = 4'd8;
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified input transaction: one or two result bytes.
    // The second result, when present, is always the flushed partial byte.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic [2:0] unused0;
        logic       last0;
        logic [7:0] byte1;
        logic [2:0] unused1;
    } bscp_entry_t;

    // Queue occupancy seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } bscp_qstat_t;

    // Mask that keeps the top nb bits of a byte; nb is already saturated to 8.
    function automatic logic [7:0] valid_mask(input logic [3:0] nb);
        return ~(BYTE_MASK >> nb);
    endfunction

endpackage

FILE: sv/bscp_front.sv
// Front end: accepts input transactions, merges bits into the partial byte
// and classifies the results. Depends on bscp_pkg.
`timescale 1ns / 1ps

module bscp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [7:0]           data_byte,
    input  logic [3:0]           valid_bits,
    input  logic                 flush,
    input  bscp_pkg::bscp_qstat_t qstat,
    output logic                 push,
    output bscp_pkg::bscp_entry_t push_entry
);

    logic [7:0] partial_byte_reg, partial_byte_next;
    logic [2:0] fill_count_reg, fill_count_next;

    logic [3:0] nb;
    logic [7:0] data_m;
    logic [7:0] acc;
    logic [3:0] total;
    logic       full_byte;
    logic [2:0] new_fill;
    logic [7:0] new_partial;
    logic       flush_part;
    logic       accept;

    assign item_ready = !qstat.full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        nb          = (valid_bits > bscp_pkg::BYTE_BITS) ? bscp_pkg::BYTE_BITS : valid_bits;
        data_m      = data_byte & bscp_pkg::valid_mask(nb);
        acc         = partial_byte_reg | (data_m >> fill_count_reg);
        total       = {1'b0, fill_count_reg} + nb;
        full_byte   = total[3];
        new_fill    = total[2:0];
        new_partial = full_byte ? 8'(data_m << (bscp_pkg::BYTE_BITS - {1'b0, fill_count_reg}))
                                : acc;
        flush_part  = flush && (new_fill != 3'd0);

        push_entry.two     = full_byte && flush_part;
        push_entry.byte0   = full_byte ? acc : new_partial;
        push_entry.unused0 = full_byte ? 3'd0 : 3'(bscp_pkg::BYTE_BITS - {1'b0, new_fill});
        push_entry.last0   = full_byte ? (flush && !flush_part) : 1'b1;
        push_entry.byte1   = new_partial;
        push_entry.unused1 = 3'(bscp_pkg::BYTE_BITS - {1'b0, new_fill});

        push = accept && (full_byte || flush_part);

        partial_byte_next = partial_byte_reg;
        fill_count_next   = fill_count_reg;
        if (accept)
        begin
            partial_byte_next = flush ? 8'd0 : new_partial;
            fill_count_next   = flush ? 3'd0 : new_fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_byte_reg <= 8'd0;
            fill_count_reg   <= 3'd0;
        end
        else
        begin
            partial_byte_reg <= partial_byte_next;
            fill_count_reg   <= fill_count_next;
        end
    end

endmodule

FILE: sv/bscp_queue.sv
// Two-entry queue of classified transactions between front and back.
// Depends on bscp_pkg.
`timescale 1ns / 1ps

module bscp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bscp_pkg::bscp_entry_t push_entry,
    input  logic                  pop,
    output bscp_pkg::bscp_entry_t head_entry,
    output bscp_pkg::bscp_qstat_t qstat
);

    localparam int unsigned PW = $clog2(bscp_pkg::QUEUE_DEPTH);

    bscp_pkg::bscp_entry_t slot_reg [bscp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign head_entry  = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == (PW+1)'(bscp_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/bscp_back.sv
// Back end: drains queued entries into the output register, one result per
// cycle unless stalled, two-result entries in turn. Depends on bscp_pkg.
`timescale 1ns / 1ps

module bscp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bscp_pkg::bscp_entry_t head_entry,
    input  bscp_pkg::bscp_qstat_t qstat,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [7:0]            packed_byte,
    output logic [2:0]            unused_bits,
    output logic                  last
);

    logic       out_valid_reg, out_valid_next;
    logic       phase_reg, phase_next;
    logic [7:0] byte_reg, byte_next;
    logic [2:0] unused_reg, unused_next;
    logic       last_reg, last_next;
    logic       slot_free;

    assign result_valid = out_valid_reg;
    assign packed_byte  = byte_reg;
    assign unused_bits  = unused_reg;
    assign last         = last_reg;

    always_comb
    begin
        slot_free      = !out_valid_reg || result_ready;
        out_valid_next = out_valid_reg && !result_ready;
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        unused_next    = unused_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (slot_free && !qstat.empty)
        begin
            out_valid_next = 1'b1;
            if (phase_reg)
            begin
                byte_next   = head_entry.byte1;
                unused_next = head_entry.unused1;
                last_next   = 1'b1;
                pop         = 1'b1;
                phase_next  = 1'b0;
            end
            else
            begin
                byte_next   = head_entry.byte0;
                unused_next = head_entry.unused0;
                last_next   = head_entry.last0;
                pop         = !head_entry.two;
                phase_next  = head_entry.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        unused_reg <= unused_next;
        last_reg   <= last_next;
    end

endmodule

FILE: sv/bit_string_concat_packer_unit.sv
// Top level of the bit string concat packer: front, queue and back.
// Depends on bscp_pkg, bscp_front, bscp_queue and bscp_back.
`timescale 1ns / 1ps

// Packs bit strings MSB first into a dense octet stream. Each input
// transaction carries a byte whose top valid_bits bits (counts above 8
// saturate to 8) are appended to the stream; lower bits are ignored. A full
// octet is emitted as soon as it fills. With flush set, any pending partial
// byte follows, its unused low bits zeroed, unused_bits giving their count
// and last set; if nothing is pending the octet completed by the flushing
// transaction carries last instead, and a flush with neither gives no
// result. One input transaction can be accepted every cycle while
// item_ready is high. item_ready drops only when the two-entry queue is
// full, which happens when the output is stalled or when transactions that
// produce two results (octet completed plus flushed remainder) come faster
// than the output can drain them, since such a transaction holds the output
// register for both of its results. The output delivers at most one result
// per cycle. result_valid rises once the result has passed through the
// queue slot and then the output register. No configuration.

module bit_string_concat_packer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic [3:0] valid_bits,
    input  logic       flush,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] packed_byte,
    output logic [2:0] unused_bits,
    output logic       last
);

    // Classified transaction between front and queue, and head of the queue.
    bscp_pkg::bscp_entry_t push_entry;
    bscp_pkg::bscp_entry_t head_entry;
    bscp_pkg::bscp_qstat_t qstat;
    logic                  push;
    logic                  pop;

    // Front: holds the partial byte and fill count, does the shift and merge.
    bscp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .data_byte  (data_byte),
        .valid_bits (valid_bits),
        .flush      (flush),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: lets the front keep accepting while the output is stalled.
    bscp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .qstat      (qstat)
    );

    // Back: serializes one or two results per entry into the output register.
    bscp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_entry   (head_entry),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .packed_byte  (packed_byte),
        .unused_bits  (unused_bits),
        .last         (last)
    );

endmodule

FILE: sv/bscp_checker.sv
// Port-level checks for the bit string concat packer, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module bscp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] packed_byte,
    input logic [2:0] unused_bits,
    input logic       last
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(packed_byte) && $stable(unused_bits) && $stable(last))
    else $error("result changed while stalled");

    // Only the final byte of a flushed stream may be partial.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (unused_bits != 3'd0) |-> last)
    else $error("partial byte without last");

    // Unused low bits of a partial byte are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((packed_byte & ~(8'hFF << unused_bits)) == 8'd0))
    else $error("unused bits not zero");

    // Nothing is offered at the output right after reset.
    assert property (@(posedge clk)
        !rst_n |=> !result_valid)
    else $error("result valid after reset");

    // Input backpressure only while a result is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
    else $error("input stalled with empty output");

endmodule

bind bit_string_concat_packer_unit bscp_checker u_bscp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .packed_byte  (packed_byte),
    .unused_bits  (unused_bits),
    .last         (last)
);
